FILE: rtl/assert_macros.svh
// Assertion helpers used by open_addressing_hash_insert_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/oahi_pkg.sv
// ----------------------------------------------------------------------------
// oahi_pkg
// Types and constants of the open-addressing hash insert unit.
// ----------------------------------------------------------------------------
package oahi_pkg;

    localparam int unsigned SIZE_W    = 13;
    localparam int unsigned KEY_W     = 31;
    localparam int unsigned SLOT_W    = 12;
    localparam int unsigned DIV_CNT_W = $clog2(KEY_W);
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned DEPTH_DEF = 4096;

    localparam logic [SIZE_W-1:0] SIZE_RESET   = 13'd4096;
    localparam logic [KEY_W-1:0]  KEY_EMPTY    = 31'd0;
    localparam logic [KEY_W-1:0]  KEY_INVALID  = 31'h7FFF_FFFF;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_QUAD   = 1'b1;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_PROBE_MODE = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_HASH  = 6'b000100,
        S_READ  = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

FILE: rtl/open_addressing_hash_insert_unit.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_insert_unit
// Open-addressing hash table insert engine with linear or quadratic probing.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries a command and a key.
// An insert hashes the key as key mod table_size, probes the slot store
// until it finds an empty slot, stores the key there and returns the slot
// and the number of slots examined; if no empty slot turns up in table_size
// probes, it reports the table full with slot zero. A clear command empties
// the whole store. Output channel (o_out_valid / i_out_stall) returns one
// result per command. Insert steps: bit-serial modulo in the divider, then
// per probe one memory read and one check, then the output register load.
// Keys of zero or all ones skip the table and go straight to the result.
// A clear sweeps the store one slot per cycle.
// One command is worked on at a time; o_in_stall is high until the unit
// is idle again, which it becomes as the result is loaded. The next command
// is taken while a result still waits.
// Reset sets table_size to 4096 and linear probing, then sweeps every
// slot of the store to empty with o_in_stall high; the APB port takes
// writes throughout. A stalled result holds in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module open_addressing_hash_insert_unit
    import oahi_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd,
    input  logic [KEY_W-1:0]     i_key,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [SIZE_W-1:0]    o_probe_count,
    output logic                 o_table_full,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int unsigned AW        = $clog2(TABLE_DEPTH);
    localparam int unsigned DEPTH_CAP = (TABLE_DEPTH > 8191) ? 8191 : TABLE_DEPTH;
    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(DEPTH_CAP);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(TABLE_DEPTH - 1);

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic                 r_clr_rpt, n_clr_rpt;
    logic                 r_out_valid, n_out_valid;
    logic [SIZE_W-1:0]    r_table_size;
    logic                 r_probe_mode;

    logic [KEY_W-1:0]     r_key, n_key;
    logic [KEY_W-1:0]     r_dvd, n_dvd;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [SIZE_W-1:0]    r_pos, n_pos;
    logic [SIZE_W-1:0]    r_count, n_count;
    logic [SIZE_W-1:0]    r_sq, n_sq;
    logic [SIZE_W-1:0]    r_dd, n_dd;
    logic [SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic [SIZE_W-1:0]    r_res_count, n_res_count;
    logic                 r_res_full, n_res_full;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic [SIZE_W-1:0]    r_out_count, n_out_count;
    logic                 r_out_full, n_out_full;
    logic [KEY_W-1:0]     r_rd_data;

    logic [KEY_W-1:0]     mem [TABLE_DEPTH];

    logic [SIZE_W-1:0]    w_size;
    logic                 w_in_acc;
    logic                 w_out_acc;
    logic                 w_cfg_wr;
    logic [SIZE_W:0]      w_trial;
    logic [SIZE_W-1:0]    w_rem_next;
    logic [SIZE_W-1:0]    w_lin_pos;
    logic [SIZE_W-1:0]    w_quad_pos;
    logic [SIZE_W-1:0]    w_sq_next;
    logic [SIZE_W-1:0]    w_dd_next;
    logic                 w_rd_en;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [KEY_W-1:0]     w_wdata;

    function automatic logic [SIZE_W-1:0] mod_add(
        input logic [SIZE_W-1:0] a,
        input logic [SIZE_W-1:0] b,
        input logic [SIZE_W-1:0] m
    );
        logic [SIZE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, m}) begin
            mod_add = SIZE_W'(sum - {1'b0, m});
        end else begin
            mod_add = sum[SIZE_W-1:0];
        end
    endfunction

    // 3 mod size for sizes of two and up
    function automatic logic [SIZE_W-1:0] init_step(input logic [SIZE_W-1:0] m);
        logic [SIZE_W-1:0] v;
        v = SIZE_W'(3);
        if (m == SIZE_W'(2)) begin
            v = SIZE_W'(1);
        end else if (m == SIZE_W'(3)) begin
            v = '0;
        end
        init_step = v;
    endfunction

    assign w_size = (r_table_size == '0)     ? SIZE_W'(1) :
                    (r_table_size > SIZE_CAP) ? SIZE_CAP  : r_table_size;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_acc  = r_out_valid && !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_slot        = r_out_slot;
    assign o_probe_count = r_out_count;
    assign o_table_full  = r_out_full;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[PADDR_W-1] == REG_PROBE_MODE) ?
                      {{(PDATA_W-1){1'b0}}, r_probe_mode} :
                      {{(PDATA_W-SIZE_W){1'b0}}, r_table_size};

    assign w_trial    = {r_pos, r_dvd[KEY_W-1]};
    assign w_rem_next = (w_trial >= {1'b0, w_size}) ? SIZE_W'(w_trial - {1'b0, w_size})
                                                    : w_trial[SIZE_W-1:0];
    assign w_lin_pos  = mod_add(r_pos, SIZE_W'(1), w_size);
    assign w_quad_pos = mod_add(r_pos, r_sq, w_size);
    assign w_sq_next  = mod_add(r_sq, r_dd, w_size);
    assign w_dd_next  = mod_add(r_dd, SIZE_W'(2), w_size);

    assign w_rd_en = (r_state == S_READ);
    assign w_we    = (r_state == S_CLEAR) ||
                     ((r_state == S_CHECK) && (r_rd_data == KEY_EMPTY));
    assign w_waddr = (r_state == S_CLEAR) ? r_clr_addr : AW'(r_pos);
    assign w_wdata = (r_state == S_CLEAR) ? KEY_EMPTY : r_key;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_rpt   = r_clr_rpt;
        n_out_valid = r_out_valid;
        n_key       = r_key;
        n_dvd       = r_dvd;
        n_div_cnt   = r_div_cnt;
        n_pos       = r_pos;
        n_count     = r_count;
        n_sq        = r_sq;
        n_dd        = r_dd;
        n_res_slot  = r_res_slot;
        n_res_count = r_res_count;
        n_res_full  = r_res_full;
        n_out_slot  = r_out_slot;
        n_out_count = r_out_count;
        n_out_full  = r_out_full;

        if (w_out_acc) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res_slot  = '0;
                    n_res_count = '0;
                    n_res_full  = 1'b0;
                    if (i_cmd == CMD_CLEAR) begin
                        n_clr_addr = '0;
                        n_clr_rpt  = 1'b1;
                        n_state    = S_CLEAR;
                    end else if ((i_key == KEY_EMPTY) || (i_key == KEY_INVALID)) begin
                        n_state = S_DONE;
                    end else begin
                        n_key     = i_key;
                        n_dvd     = i_key;
                        n_pos     = '0;
                        n_div_cnt = DIV_CNT_W'(KEY_W - 1);
                        n_state   = S_HASH;
                    end
                end
            end
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = r_clr_rpt ? S_DONE : S_IDLE;
                end
            end
            S_HASH: begin
                n_pos     = w_rem_next;
                n_dvd     = {r_dvd[KEY_W-2:0], 1'b0};
                n_div_cnt = r_div_cnt - DIV_CNT_W'(1);
                if (r_div_cnt == '0) begin
                    n_count = SIZE_W'(1);
                    n_sq    = SIZE_W'(1);
                    n_dd    = init_step(w_size);
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_rd_data == KEY_EMPTY) begin
                    n_res_slot  = r_pos[SLOT_W-1:0];
                    n_res_count = r_count;
                    n_res_full  = 1'b0;
                    n_state     = S_DONE;
                end else if (r_count >= w_size) begin
                    n_res_slot  = '0;
                    n_res_count = r_count;
                    n_res_full  = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    if (r_probe_mode == MODE_QUAD) begin
                        n_pos = w_quad_pos;
                        n_sq  = w_sq_next;
                        n_dd  = w_dd_next;
                    end else begin
                        n_pos = w_lin_pos;
                    end
                    n_count = r_count + SIZE_W'(1);
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = r_res_slot;
                    n_out_count = r_res_count;
                    n_out_full  = r_res_full;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_rpt    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_table_size <= SIZE_RESET;
            r_probe_mode <= MODE_LINEAR;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_rpt   <= n_clr_rpt;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                if (paddr[PADDR_W-1] == REG_TABLE_SIZE) begin
                    r_table_size <= pwdata[SIZE_W-1:0];
                end else begin
                    r_probe_mode <= pwdata[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_dvd       <= n_dvd;
        r_div_cnt   <= n_div_cnt;
        r_pos       <= n_pos;
        r_count     <= n_count;
        r_sq        <= n_sq;
        r_dd        <= n_dd;
        r_res_slot  <= n_res_slot;
        r_res_count <= n_res_count;
        r_res_full  <= n_res_full;
        r_out_slot  <= n_out_slot;
        r_out_count <= n_out_count;
        r_out_full  <= n_out_full;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[AW'(r_pos)];
        end
    end

    `ASSERT_IMPL(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall,
                 "busy but not stalling")
    `ASSERT_IMPL(a_pos_in_range, i_clk, i_rst_n, r_state == S_CHECK, r_pos < w_size,
                 "probe position out of range")
    `ASSERT_IMPL(a_count_in_range, i_clk, i_rst_n, r_state == S_CHECK,
                 (r_count != '0) && (r_count <= w_size), "probe count out of range")
    `ASSERT_IMPL(a_full_slot_zero, i_clk, i_rst_n, r_out_valid && r_out_full,
                 r_out_slot == '0, "full result with nonzero slot")
    `ASSERT_NEXT(a_clear_sweeps, i_clk, i_rst_n, w_in_acc && (i_cmd == CMD_CLEAR),
                 r_state == S_CLEAR, "clear did not start sweep")

endmodule
